### sv/bba_pkg.sv
// Shared definitions for the bitmap block allocator: parameter defaults,
// status and opcode codes. No dependencies.
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  localparam int COUNT_W  = 13;
  localparam int NUMBER_W = 12;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_RANGE       = 2'd3
  } status_t;

  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

### sv/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg and bba_ram.
//
// Each block owns one used bit in a bitmap RAM of MAX_BLOCKS/WORD_BITS words
// (128 words of 32 bits by default). An allocate item walks the bitmap from
// word 0, one word per cycle through the RAM read port, and claims the lowest
// free block below the effective count (block_count, capped at MAX_BLOCKS).
// A free item walks to the word that holds its block and clears the bit, or
// reports a double free if it is already clear. busy is high from the cycle
// after start is taken until the result strobe; a free past the count is
// answered with a range status without a scan and never raises busy. The
// result appears on allocated_block and status with done high for one cycle
// and cannot be held off. The bitmap is all free after reset with no clearing
// pass: a per-word valid bit marks rows never written, which read as zero.
// config_data may be written whenever busy is low.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          config_write,
  input  logic [bba_pkg::COUNT_W-1:0]   config_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [bba_pkg::NUMBER_W-1:0]  block_number,
  output logic                          done,
  output logic [bba_pkg::NUMBER_W-1:0]  allocated_block,
  output logic [bba_pkg::STATUS_W-1:0]  status
);

  import bba_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BI_W      = $clog2(WORD_BITS);
  localparam int SPAN      = MAP_WORDS * WORD_BITS;
  localparam int SPAN_W    = $clog2(SPAN + WORD_BITS + 1);
  localparam int AW        = (SPAN_W > COUNT_W) ? SPAN_W : COUNT_W;

  state_t                 state;
  logic [COUNT_W-1:0]     block_count;
  logic                   op;
  logic [NUMBER_W-1:0]    num;
  logic [WA_W-1:0]        raddr;
  logic [AW-1:0]          rbase;
  logic                   pend;
  logic [WA_W-1:0]        pword;
  logic [AW-1:0]          pbase;
  logic                   pvld;
  logic [MAP_WORDS-1:0]   vld;

  logic [WORD_BITS-1:0]   rdata;
  logic [WORD_BITS-1:0]   pdata;
  logic [AW-1:0]          limit;
  logic [AW-1:0]          rem;
  logic [AW-1:0]          num_x;
  logic [WORD_BITS-1:0]   mask;
  logic [WORD_BITS-1:0]   freeb;
  logic [BI_W-1:0]        idx;
  logic [BI_W-1:0]        bsel;
  logic                   at_end;
  logic                   hit_word;
  logic                   check;
  logic                   fin;
  status_t                fin_status;
  logic [NUMBER_W-1:0]    fin_block;
  logic                   ram_we;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [AW-1:0]          claim;
  logic                   accept;
  logic                   range_err;
  logic                   raddr_ok;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // Counts above capacity act as the capacity.
  assign limit = (AW'(block_count) > AW'(MAX_BLOCKS)) ? AW'(MAX_BLOCKS) : AW'(block_count);
  assign num_x = AW'(block_number);
  assign range_err = (opcode == OPC_FREE) && (num_x >= limit);
  assign raddr_ok  = ({1'b0, raddr} < (WA_W + 1)'(MAP_WORDS));

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .ADDR_W(WA_W)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pword),
    .wdata(ram_wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Check stage: one bitmap word per cycle.
  always_comb begin
    pdata  = pvld ? rdata : '0;
    rem    = limit - pbase;
    at_end = (pbase >= limit);
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (AW'(i) < rem) && !at_end;
    end
    freeb = ~pdata & mask;
    idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (freeb[i]) begin
        idx = BI_W'(i);
      end
    end
    claim    = pbase + AW'(idx);
    hit_word = (AW'(num) < pbase + AW'(WORD_BITS));
    bsel     = BI_W'(AW'(num) - pbase);
    check    = (state == S_SCAN) && pend;

    fin        = 1'b0;
    fin_status = ST_OK;
    fin_block  = '0;
    ram_we     = 1'b0;
    ram_wdata  = pdata;
    if (check) begin
      if (op == OPC_ALLOC) begin
        if (at_end) begin
          fin        = 1'b1;
          fin_status = ST_FULL;
        end else if (|freeb) begin
          fin       = 1'b1;
          fin_block = claim[NUMBER_W-1:0];
          ram_we    = 1'b1;
          ram_wdata = pdata | (WORD_BITS'(1) << idx);
        end
      end else if (hit_word) begin
        fin = 1'b1;
        if (!pdata[bsel]) begin
          fin_status = ST_DOUBLE_FREE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = pdata & ~(WORD_BITS'(1) << bsel);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_count <= COUNT_RESET;
      pend        <= 1'b0;
      vld         <= '0;
      done        <= 1'b0;
    end else begin
      done <= (accept && range_err) || ((state == S_SCAN) && fin);
      if (config_write) begin
        block_count <= config_data;
      end
      if (ram_we) begin
        vld[pword] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (range_err) begin
              status          <= ST_RANGE;
              allocated_block <= '0;
            end else begin
              state <= S_SCAN;
              op    <= opcode;
              num   <= block_number;
              raddr <= '0;
              rbase <= '0;
              pend  <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // Issue the next word while checking the previous one.
          raddr <= raddr + WA_W'(1);
          rbase <= rbase + AW'(WORD_BITS);
          pend  <= !fin;
          pword <= raddr;
          pbase <= rbase;
          pvld  <= raddr_ok && vld[raddr];
          if (fin) begin
            state           <= S_IDLE;
            status          <= fin_status;
            allocated_block <= fin_block;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_SCAN || accept))
    else $error("result strobe without an item in flight");

  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SCAN) && pend && fin)
    else $error("bitmap write outside a finishing check");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (allocated_block == '0))
    else $error("failed item returned a nonzero block");

  a_busy_drops: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && fin |=> !busy && done)
    else $error("scan finished without releasing busy");
`endif

endmodule

### sv/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### dv/testbench.sv
// Self-checking testbench for bitmap_block_allocator: a directed table, a fill
// run of allocates, then random allocate/free traffic under several block counts.
// Depends on bba_pkg and the allocator RTL; results are checked by an in-bench predictor.
module testbench;
  import bba_pkg::*;

  localparam int MAP_BLOCKS    = MAX_BLOCKS_DEF;
  localparam int MAP_WORDS     = MAX_BLOCKS_DEF / WORD_BITS_DEF;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = MAP_WORDS + 8;
  localparam int FILL_ITEMS    = 300;
  localparam int PHASE_ITEMS   = 70;
  localparam int NUM_PHASES    = 10;
  localparam int NUM_STEPS     = 28;

  typedef struct packed {
    logic [NUMBER_W-1:0] blk;
    status_t             st;
  } alloc_result_t;

  typedef struct packed {
    bit            known;
    alloc_result_t res;
  } plan_t;

  typedef struct packed {
    bit                  is_cfg;
    logic                op;
    logic [COUNT_W-1:0]  arg;
    bit                  known;
    logic [NUMBER_W-1:0] want_blk;
    status_t             want_st;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                config_write = 1'b0;
  logic [COUNT_W-1:0]  config_data = COUNT_RESET;
  logic                start = 1'b0;
  logic                opcode = OPC_ALLOC;
  logic [NUMBER_W-1:0] block_number = '0;
  logic                busy;
  logic                done;
  logic [NUMBER_W-1:0] allocated_block;
  logic [STATUS_W-1:0] status;

  // predictor state: one used bit per block, plus the block count register
  bit                  used_map [MAP_BLOCKS];
  logic [COUNT_W-1:0]  model_count;

  alloc_result_t       expected_q [$];
  plan_t               plan_q [$];
  int                  mismatches = 0;
  int                  results_seen = 0;
  int                  stall_cycles = 0;
  int                  items_sent = 0;
  int                  settings_used = 0;
  logic [COUNT_W-1:0]  active_count = COUNT_RESET;

  // arg is the block count on a config row and the block number on an item row
  step_row_t directed_steps [NUM_STEPS] = '{
    '{1'b0, OPC_FREE,  13'd0,    1'b1, 12'd0, ST_DOUBLE_FREE},
    '{1'b0, OPC_FREE,  13'd4095, 1'b1, 12'd0, ST_DOUBLE_FREE},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b1, 12'd0, ST_OK},
    '{1'b0, OPC_ALLOC, 13'd4095, 1'b1, 12'd1, ST_OK},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b1, 12'd2, ST_OK},
    '{1'b0, OPC_FREE,  13'd1,    1'b1, 12'd0, ST_OK},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b1, 12'd1, ST_OK},
    '{1'b0, OPC_FREE,  13'd1,    1'b1, 12'd0, ST_OK},
    '{1'b0, OPC_FREE,  13'd1,    1'b1, 12'd0, ST_DOUBLE_FREE},
    '{1'b1, OPC_ALLOC, 13'd2,    1'b0, 12'd0, ST_OK},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b1, 12'd1, ST_OK},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b1, 12'd0, ST_FULL},
    '{1'b0, OPC_FREE,  13'd2,    1'b1, 12'd0, ST_RANGE},
    '{1'b0, OPC_FREE,  13'd4095, 1'b1, 12'd0, ST_RANGE},
    '{1'b0, OPC_FREE,  13'd0,    1'b1, 12'd0, ST_OK},
    '{1'b1, OPC_ALLOC, 13'd0,    1'b0, 12'd0, ST_OK},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b1, 12'd0, ST_FULL},
    '{1'b0, OPC_FREE,  13'd0,    1'b1, 12'd0, ST_RANGE},
    '{1'b1, OPC_ALLOC, 13'd8191, 1'b0, 12'd0, ST_OK},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b1, 12'd0, ST_OK},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b1, 12'd3, ST_OK},
    '{1'b0, OPC_FREE,  13'd2,    1'b1, 12'd0, ST_OK},
    '{1'b1, OPC_ALLOC, 13'd1,    1'b0, 12'd0, ST_OK},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b1, 12'd0, ST_FULL},
    '{1'b0, OPC_FREE,  13'd1,    1'b1, 12'd0, ST_RANGE},
    '{1'b1, OPC_ALLOC, 13'd4097, 1'b0, 12'd0, ST_OK},
    '{1'b0, OPC_FREE,  13'd4095, 1'b1, 12'd0, ST_DOUBLE_FREE},
    '{1'b0, OPC_ALLOC, 13'd0,    1'b0, 12'd0, ST_OK}
  };

  bitmap_block_allocator i_dut (
    .clk             (clk),
    .rst             (rst),
    .config_write    (config_write),
    .config_data     (config_data),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .block_number    (block_number),
    .done            (done),
    .allocated_block (allocated_block),
    .status          (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int effective_limit(logic [COUNT_W-1:0] count);
    return (count > MAP_BLOCKS) ? MAP_BLOCKS : int'(count);
  endfunction

  // first-fit allocate or free against the predictor bitmap
  function automatic alloc_result_t step_allocator(logic op, logic [NUMBER_W-1:0] num);
    alloc_result_t r;
    int            lim;
    int            b;
    lim   = effective_limit(model_count);
    r.blk = '0;
    if (op == OPC_ALLOC) begin
      r.st = ST_FULL;
      b = 0;
      while (b < lim && r.st == ST_FULL) begin
        if (!used_map[b]) begin
          used_map[b] = 1'b1;
          r.blk = b[NUMBER_W-1:0];
          r.st  = ST_OK;
        end
        b++;
      end
    end else if (int'(num) >= lim) begin
      r.st = ST_RANGE;
    end else if (!used_map[num]) begin
      r.st = ST_DOUBLE_FREE;
    end else begin
      used_map[num] = 1'b0;
      r.st = ST_OK;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    alloc_result_t predicted;
    plan_t         plan;
    if (rst) begin
      foreach (used_map[i]) used_map[i] = 1'b0;
      model_count  = COUNT_RESET;
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (config_write) model_count = config_data;
      if (done) begin
        stall_cycles = 0;
        results_seen++;
        got.blk = allocated_block;
        got.st  = status_t'(status);
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("t=%0t: result blk=%0d status=%0d with no item outstanding",
                     $time, got.blk, got.st);
        end else begin
          want = expected_q.pop_front();
          if (got.blk !== want.blk || got.st !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("t=%0t: expected blk=%0d status=%0d, got blk=%0d status=%0d",
                       $time, want.blk, want.st, got.blk, got.st);
          end
        end
      end
      if (start && !busy) begin
        stall_cycles = 0;
        plan      = plan_q.pop_front();
        predicted = step_allocator(opcode, block_number);
        expected_q.push_back(plan.known ? plan.res : predicted);
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("t=%0t: no item or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("[bitmap_block_allocator] ERROR");
        $finish;
      end
    end
  end

  task automatic issue_item(logic op, logic [NUMBER_W-1:0] num, bit known,
                            alloc_result_t want, int gap);
    plan_t p;
    p.known = known;
    p.res   = want;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    plan_q.push_back(p);
    start        <= 1'b1;
    opcode       <= op;
    block_number <= num;
    items_sent++;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] value);
    start <= 1'b0;
    // hold off until every outstanding result is back
    while (plan_q.size() != 0 || expected_q.size() != 0) @(negedge clk);
    @(posedge clk);
    config_write <= 1'b1;
    config_data  <= value;
    @(posedge clk);
    config_write <= 1'b0;
    active_count = value;
    settings_used++;
  endtask

  function automatic int pick_gap(bit allow);
    if (!allow || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 6);
  endfunction

  initial begin
    logic [COUNT_W-1:0]  phase_counts [NUM_PHASES];
    alloc_result_t       want;
    alloc_result_t       none;
    logic                op;
    logic [NUMBER_W-1:0] num;
    int                  lim;
    int                  directed_items;
    int                  fill_items;
    none = '0;
    phase_counts = '{13'd64, 13'd33, 13'd4096, 13'd31, 13'd1, 13'd200, 13'd0,
                     13'd8191, 13'd32, 13'd0};
    phase_counts[NUM_PHASES-1] = COUNT_W'($urandom_range(1, 8191));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        write_count(directed_steps[i].arg);
      end else begin
        want.blk = directed_steps[i].want_blk;
        want.st  = directed_steps[i].want_st;
        issue_item(directed_steps[i].op, directed_steps[i].arg[NUMBER_W-1:0],
                   directed_steps[i].known, want, 0);
      end
    end
    directed_items = items_sent;

    // fill the low end of the device so later scans walk many words
    write_count(COUNT_RESET);
    repeat (FILL_ITEMS)
      issue_item(OPC_ALLOC, NUMBER_W'($urandom_range(0, MAP_BLOCKS - 1)), 1'b0, none,
                 pick_gap(1'b1));
    fill_items = items_sent - directed_items;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_count(phase_counts[p]);
      lim = effective_limit(active_count);
      repeat (PHASE_ITEMS) begin
        op  = 1'($urandom_range(0, 1));
        num = NUMBER_W'($urandom_range(0, MAP_BLOCKS - 1));
        // aim most frees inside the count so they hit used blocks
        if (op == OPC_FREE && lim > 0 && $urandom_range(0, 4) != 0)
          num = NUMBER_W'($urandom_range(0, lim - 1));
        issue_item(op, num, 1'b0, none, pick_gap(p != NUM_PHASES - 1));
      end
    end

    start <= 1'b0;
    while (plan_q.size() != 0 || expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d directed, %0d fill, %0d random) under %0d block counts,",
             items_sent, directed_items, fill_items,
             items_sent - directed_items - fill_items, settings_used);
    $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[bitmap_block_allocator] OK");
    end else begin
      $display("[bitmap_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

### bitmap_block_allocator.f
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bitmap_block_allocator.sv
dv/testbench.sv
